// ===== sv/set_assoc_cache_lru_lookup_defines.svh =====
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_lookup_defines
// assertion macros used by the top-level lookup design file
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_CACHE_LRU_LOOKUP_DEFINES_SVH
`define SET_ASSOC_CACHE_LRU_LOOKUP_DEFINES_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define SACL_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication
`define SACL_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define SACL_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define SACL_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== sv/sacl_pkg.sv =====
// ----------------------------------------------------------------------------
// sacl_pkg
// shared widths, defaults and register codes of the cache lookup
// ----------------------------------------------------------------------------
package sacl_pkg;

  localparam int ADDR_W = 32;
  localparam int TAG_W  = 32;
  // widest set index the configuration can produce (index_bits up to 15)
  localparam int IDX_W  = 15;

  localparam int SACL_SETS       = 1024;
  localparam int SACL_WAYS       = 8;
  localparam int SACL_STAMP_BITS = 32;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INDEX_BITS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS_IN_USE = 2'd2;

  localparam logic [2:0] OFFSET_BITS_RST = 3'd2;
  localparam logic [3:0] INDEX_BITS_RST  = 4'd10;
  localparam logic [3:0] WAYS_IN_USE_RST = 4'd4;

endpackage

// ===== sv/sacl_set_map.sv =====
// ----------------------------------------------------------------------------
// sacl_set_map
// splits an address into set index and tag, folds the index into the store
// ----------------------------------------------------------------------------
module sacl_set_map
  import sacl_pkg::*;
#(
  parameter int SETS = SACL_SETS,
  localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [ADDR_W-1:0] address,
  input  logic [2:0]        offset_bits,
  input  logic [3:0]        index_bits,
  output logic [SET_W-1:0]  set_idx,
  output logic [TAG_W-1:0]  tag,
  output logic              done
);

  localparam bit SETS_POW2 = (SETS & (SETS - 1)) == 0;
  localparam int MOD_STEPS = SETS_POW2 ? 0 :
                             ((IDX_W - $clog2(SETS) + 1) > 0 ? IDX_W - $clog2(SETS) + 1 : 0);
  localparam int CNT_W  = $clog2(IDX_W + 2);
  localparam int MASK_W = IDX_W + 1;
  localparam int SUB_W  = 32;

  logic [ADDR_W-1:0] shifted;
  logic [MASK_W-1:0] imask;
  logic [IDX_W-1:0]  masked;
  logic [TAG_W-1:0]  tag_next;
  logic [IDX_W-1:0]  rem;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic [SUB_W-1:0]  sub;
  logic              sub_ok;

  always_comb begin
    shifted  = address >> offset_bits;
    imask    = (MASK_W'(1) << index_bits) - MASK_W'(1);
    masked   = shifted[IDX_W-1:0] & imask[IDX_W-1:0];
    tag_next = address >> (5'(offset_bits) + 5'(index_bits));
    // restoring reduction, one multiple of the set count per cycle
    sub      = SUB_W'(SETS) << (cnt - CNT_W'(1));
    sub_ok   = SUB_W'(rem) >= sub;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(MOD_STEPS);
    end else if (busy) begin
      if (cnt != '0) begin
        cnt <= cnt - CNT_W'(1);
      end else begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= masked;
      tag <= tag_next;
    end else if (busy && cnt != '0 && sub_ok) begin
      rem <= rem - IDX_W'(sub);
    end
  end

  assign set_idx = SETS_POW2 ? SET_W'(SUB_W'(rem) & SUB_W'(SETS - 1)) : SET_W'(rem);
  assign done    = busy && (cnt == '0);

endmodule

// ===== sv/sacl_tag_ram.sv =====
// ----------------------------------------------------------------------------
// sacl_tag_ram
// one row per set: valid bits, tags and stamps of all ways
// ----------------------------------------------------------------------------
module sacl_tag_ram
  import sacl_pkg::*;
#(
  parameter int SETS       = SACL_SETS,
  parameter int WAYS       = SACL_WAYS,
  parameter int STAMP_BITS = SACL_STAMP_BITS,
  localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [SET_W-1:0]                     waddr,
  input  logic [WAYS-1:0]                      wvld,
  input  logic [WAYS-1:0][TAG_W-1:0]           wtag,
  input  logic [WAYS-1:0][STAMP_BITS-1:0]      wstamp,
  input  logic                                 re,
  input  logic [SET_W-1:0]                     raddr,
  output logic [WAYS-1:0]                      rvld,
  output logic [WAYS-1:0][TAG_W-1:0]           rtag,
  output logic [WAYS-1:0][STAMP_BITS-1:0]      rstamp
);

  localparam int ROW_W = WAYS * (1 + TAG_W + STAMP_BITS);

  logic [ROW_W-1:0] mem [SETS];
  logic [ROW_W-1:0] rd_q;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {wvld, wtag, wstamp};
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_q <= mem[raddr];
    end
  end

  assign {rvld, rtag, rstamp} = rd_q;

endmodule

// ===== sv/sacl_lru_pick.sv =====
// ----------------------------------------------------------------------------
// sacl_lru_pick
// hit detection, first free way and a shared min-stamp tree, one level a cycle
// ----------------------------------------------------------------------------
module sacl_lru_pick
  import sacl_pkg::*;
#(
  parameter int WAYS       = SACL_WAYS,
  parameter int STAMP_BITS = SACL_STAMP_BITS,
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1
) (
  input  logic                            clk,
  input  logic                            load,
  input  logic                            step,
  input  logic [WAYS-1:0]                 vld,
  input  logic [WAYS-1:0][TAG_W-1:0]      tag,
  input  logic [WAYS-1:0][STAMP_BITS-1:0] stamp,
  input  logic [TAG_W-1:0]                tag_in,
  input  logic [3:0]                      ways_in_use,
  output logic                            hit,
  output logic [WAY_W-1:0]                victim
);

  localparam int NODES = 2 ** WAY_W;

  logic [WAYS-1:0]       in_range;
  logic [WAYS-1:0]       match;
  logic [WAYS-1:0]       free;
  logic [WAY_W-1:0]      match_way;
  logic [WAY_W-1:0]      free_way;

  // leaves padded out to the full tree, unused leaves disabled
  logic [NODES-1:0]                  en_pad;
  logic [NODES-1:0][STAMP_BITS-1:0]  stamp_pad;

  logic                  hit_q;
  logic [WAY_W-1:0]      hit_way_q;
  logic                  free_q;
  logic [WAY_W-1:0]      free_way_q;

  logic                  nd_en    [NODES];
  logic [STAMP_BITS-1:0] nd_stamp [NODES];
  logic [WAY_W-1:0]      nd_idx   [NODES];

  // zero ways in use behaves as one way
  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      in_range[i] = (i == 0) || ({28'd0, ways_in_use} > 32'(i));
      match[i]    = in_range[i] && vld[i] && (tag[i] == tag_in);
      free[i]     = in_range[i] && !vld[i];
    end
    match_way = '0;
    free_way  = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (match[i]) begin
        match_way = WAY_W'(i);
      end
      if (free[i]) begin
        free_way = WAY_W'(i);
      end
    end
  end

  assign en_pad    = NODES'(in_range);
  assign stamp_pad = (NODES * STAMP_BITS)'(stamp);

  always_ff @(posedge clk) begin
    if (load) begin
      hit_q      <= |match;
      hit_way_q  <= match_way;
      free_q     <= |free;
      free_way_q <= free_way;
      for (int i = 0; i < NODES; i++) begin
        nd_en[i]    <= en_pad[i];
        nd_stamp[i] <= stamp_pad[i];
        nd_idx[i]   <= WAY_W'(i);
      end
    end else if (step) begin
      // left node wins ties so the lower way is kept
      for (int i = 0; i < NODES / 2; i++) begin
        if (nd_en[2*i+1] && (!nd_en[2*i] || nd_stamp[2*i+1] < nd_stamp[2*i])) begin
          nd_en[i]    <= 1'b1;
          nd_stamp[i] <= nd_stamp[2*i+1];
          nd_idx[i]   <= nd_idx[2*i+1];
        end else begin
          nd_en[i]    <= nd_en[2*i];
          nd_stamp[i] <= nd_stamp[2*i];
          nd_idx[i]   <= nd_idx[2*i];
        end
      end
    end
  end

  assign hit    = hit_q;
  assign victim = hit_q ? hit_way_q : (free_q ? free_way_q : nd_idx[0]);

endmodule

// ===== sv/set_assoc_cache_lru_lookup.sv =====
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_lookup
// set-associative tag store with least-recently-used replacement
// ----------------------------------------------------------------------------
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+-------------------------------
//  in       | in_valid / in_stall (out)   | address
//  out      | out_valid / out_stall (in)  | hit, way, hits, misses
//  cfg      | cfg_valid / cfg_ready       | cfg_index, cfg_data
//
//  from acceptance to the next acceptance an item passes the set map, the
//  set row read, the one-level-per-cycle victim tree and the read-modify-
//  write of the set row; set counts that are not a power of two also pass
//  the steps of the set index reduction
//  after reset the tag ram is swept row by row to clear the valid bits; no
//  item is taken during the sweep, configuration writes are taken at any
//  time since cfg_ready is tied high
//  a finished item waits in the output register; a new item is accepted
//  meanwhile and only its write-back waits for the output to drain
//
`include "set_assoc_cache_lru_lookup_defines.svh"

module set_assoc_cache_lru_lookup
  import sacl_pkg::*;
#(
  parameter int SETS       = SACL_SETS,
  parameter int WAYS       = SACL_WAYS,
  parameter int STAMP_BITS = SACL_STAMP_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  // access items
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [ADDR_W-1:0]     address,
  // result items
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  hit,
  output logic [2:0]            way,
  output logic [31:0]           hits,
  output logic [31:0]           misses,
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int LVL_W = $clog2(WAY_W + 1);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_MAP    = 3'd2;
  localparam logic [2:0] ST_LOOK   = 3'd3;
  localparam logic [2:0] ST_REDUCE = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  logic [2:0]       state;
  logic [2:0]       state_next;
  logic [SET_W-1:0] clr_cnt;
  logic [LVL_W-1:0] lvl_cnt;

  // configuration registers
  logic [2:0] offset_bits;
  logic [3:0] index_bits;
  logic [3:0] ways_in_use;

  // running totals and the access stamp
  logic [31:0]           hit_total;
  logic [31:0]           miss_total;
  logic [STAMP_BITS-1:0] access_stamp;

  logic             in_acc;
  logic             done_go;

  // set map
  logic [SET_W-1:0] map_set;
  logic [TAG_W-1:0] map_tag;
  logic             map_done;

  // tag ram
  logic                            ram_we;
  logic [SET_W-1:0]                ram_waddr;
  logic [WAYS-1:0]                 ram_wvld;
  logic [WAYS-1:0][TAG_W-1:0]      ram_wtag;
  logic [WAYS-1:0][STAMP_BITS-1:0] ram_wstamp;
  logic                            ram_re;
  logic [WAYS-1:0]                 ram_rvld;
  logic [WAYS-1:0][TAG_W-1:0]      ram_rtag;
  logic [WAYS-1:0][STAMP_BITS-1:0] ram_rstamp;

  // victim choice
  logic             pick_load;
  logic             pick_step;
  logic             pick_hit;
  logic [WAY_W-1:0] pick_way;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  // write-back happens only when the output slot is free or draining
  assign done_go   = (state == ST_DONE) && (!out_valid || !out_stall);

  // --------------------------------------------------------------------------
  // configuration
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      offset_bits <= OFFSET_BITS_RST;
      index_bits  <= INDEX_BITS_RST;
      ways_in_use <= WAYS_IN_USE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_OFFSET_BITS: offset_bits <= cfg_data[2:0];
        REG_INDEX_BITS:  index_bits  <= cfg_data;
        REG_WAYS_IN_USE: ways_in_use <= cfg_data;
        default: ;  // unknown register, write dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_cnt == SET_W'(SETS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          state_next = ST_MAP;
        end
      end
      ST_MAP: begin
        if (map_done) begin
          state_next = ST_LOOK;
        end
      end
      ST_LOOK:   state_next = ST_REDUCE;
      ST_REDUCE: begin
        if (lvl_cnt == LVL_W'(WAY_W - 1)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (done_go) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
      lvl_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + SET_W'(1);
      end
      if (state == ST_LOOK) begin
        lvl_cnt <= '0;
      end else if (state == ST_REDUCE) begin
        lvl_cnt <= lvl_cnt + LVL_W'(1);
      end
    end
  end

  // --------------------------------------------------------------------------
  // totals, stamp and output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_total    <= '0;
      miss_total   <= '0;
      access_stamp <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (done_go) begin
        out_valid    <= 1'b1;
        access_stamp <= access_stamp + STAMP_BITS'(1);
        if (pick_hit) begin
          hit_total <= hit_total + 32'd1;
        end else begin
          miss_total <= miss_total + 32'd1;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done_go) begin
      hit <= pick_hit;
      way <= 3'(pick_way);
    end
  end

  // totals only move on a write-back, which waits for the output to drain
  assign hits   = hit_total;
  assign misses = miss_total;

  // --------------------------------------------------------------------------
  // tag ram access: clearing sweep, set row read, or the updated row on write-back
  // --------------------------------------------------------------------------
  assign ram_re    = (state == ST_MAP) && map_done;
  assign ram_we    = (state == ST_CLEAR) || done_go;
  assign ram_waddr = (state == ST_CLEAR) ? clr_cnt : map_set;

  always_comb begin
    ram_wvld   = '0;
    ram_wtag   = '0;
    ram_wstamp = '0;
    if (state != ST_CLEAR) begin
      ram_wvld   = ram_rvld | (WAYS'(1) << pick_way);
      ram_wtag   = ram_rtag;
      ram_wstamp = ram_rstamp;
      for (int i = 0; i < WAYS; i++) begin
        if (WAY_W'(i) == pick_way) begin
          ram_wstamp[i] = access_stamp;
          if (!pick_hit) begin
            ram_wtag[i] = map_tag;
          end
        end
      end
    end
  end

  assign pick_load = (state == ST_LOOK);
  assign pick_step = (state == ST_REDUCE);

  sacl_set_map #(
    .SETS (SETS)
  ) u_set_map (
    .clk         (clk),
    .rst         (rst),
    .start       (in_acc),
    .address     (address),
    .offset_bits (offset_bits),
    .index_bits  (index_bits),
    .set_idx     (map_set),
    .tag         (map_tag),
    .done        (map_done)
  );

  sacl_tag_ram #(
    .SETS       (SETS),
    .WAYS       (WAYS),
    .STAMP_BITS (STAMP_BITS)
  ) u_tag_ram (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (ram_waddr),
    .wvld   (ram_wvld),
    .wtag   (ram_wtag),
    .wstamp (ram_wstamp),
    .re     (ram_re),
    .raddr  (map_set),
    .rvld   (ram_rvld),
    .rtag   (ram_rtag),
    .rstamp (ram_rstamp)
  );

  sacl_lru_pick #(
    .WAYS       (WAYS),
    .STAMP_BITS (STAMP_BITS)
  ) u_lru_pick (
    .clk         (clk),
    .load        (pick_load),
    .step        (pick_step),
    .vld         (ram_rvld),
    .tag         (ram_rtag),
    .stamp       (ram_rstamp),
    .tag_in      (map_tag),
    .ways_in_use (ways_in_use),
    .hit         (pick_hit),
    .victim      (pick_way)
  );

  // --------------------------------------------------------------------------
  // checks
  // --------------------------------------------------------------------------
  // the read of a set never overlaps a write of the ram
  `SACL_ASSERT_IMP(a_no_rw_overlap, clk, rst, ram_we, !ram_re)
  // an accepted item always starts with the set map
  `SACL_ASSERT_NXT(a_accept_to_map, clk, rst, in_acc, state == ST_MAP)
  // every write-back counts exactly one hit or one miss
  `SACL_ASSERT_NXT(a_count_step, clk, rst, done_go,
                   (hits + misses) == ($past(hits) + $past(misses) + 32'd1))
  // the clearing sweep takes no item
  `SACL_ASSERT_IMP(a_clear_blocks_input, clk, rst, state == ST_CLEAR, in_stall)

endmodule

// ===== test/tb_set_assoc_cache_lru_lookup.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_set_assoc_cache_lru_lookup
// self-checking bench for the lru cache tag lookup
//
// a queue-fed driver offers addresses with random gaps and a monitor stalls
// the result side at random. every accepted address runs through an in-bench
// model of the tag, valid and stamp rows, and each result item is checked
// field by field against the oldest prediction. the run walks through a
// series of geometry settings, the extremes among them, with directed
// warm-up items first.
// ----------------------------------------------------------------------------
module tb_set_assoc_cache_lru_lookup;
  import sacl_pkg::*;

  localparam int LINES       = SACL_SETS * SACL_WAYS;
  localparam int STALL_LIMIT = 5000;   // cycles with no handshake at all
  localparam int LONG_HOLD   = 400;    // receiver hold-off that backs up the block
  localparam int SETTLE      = 16;     // quiet time after the last result, so the block is idle
  localparam int PHASE_ITEMS = 110;

  // register index the block does not decode, writes to it must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // directed warm-up under the reset geometry (offset 2, index 10, 4 ways)
  localparam logic [31:0] WARMUP_ADDRS [15] = '{
    32'h0000_0000,  // cold miss, set 0 way 0
    32'hFFFF_FFFF,  // all ones, top set
    32'h0000_0003,  // same block as the first, hit
    32'h0000_1000,  // fill the rest of set 0
    32'h0000_2000,
    32'h0000_3000,
    32'h0000_0000,  // refresh way 0
    32'h0000_4000,  // full set, evicts the oldest (way 1)
    32'h0000_1000,  // evicted line comes back, evicts way 2
    32'hFFFF_FFFC,  // hit on the all-ones block
    32'h5555_5555,
    32'hAAAA_AAAA,
    32'h5555_5554,  // hit in the same block
    32'h8000_0000,
    32'h7FFF_FFFF
  };

  typedef struct packed {
    logic        hit;
    logic [2:0]  way;
    logic [31:0] hits;
    logic [31:0] misses;
  } lookup_result_t;

  // dut ports, all inputs known from time zero
  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  logic [ADDR_W-1:0]     address   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  hit;
  logic [2:0]            way;
  logic [31:0]           hits;
  logic [31:0]           misses;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // bench copy of the cache state
  logic        line_valid [LINES];
  logic [31:0] line_tag   [LINES];
  logic [31:0] line_stamp [LINES];
  logic [31:0] stamp_clock;
  logic [31:0] hit_tally;
  logic [31:0] miss_tally;
  logic [2:0]  cur_offset_bits;
  logic [3:0]  cur_index_bits;
  logic [3:0]  cur_ways;

  logic [31:0]    addr_backlog [$];   // addresses not yet offered
  lookup_result_t results_due  [$];   // predictions waiting for their item

  int mismatch_count = 0;

  // pacing controls, set by the sequencer between phases
  bit sender_quiet   = 1'b0;
  bit receiver_quiet = 1'b0;
  int hold_req       = 0;

  // driver and monitor private counters
  int             gap_left   = 0;
  int             stall_left = 0;
  int             hold_left  = 0;
  int             hold_seen  = 0;
  lookup_result_t due;

  set_assoc_cache_lru_lookup dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .address   (address),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .hit       (hit),
    .way       (way),
    .hits      (hits),
    .misses    (misses),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 45) return 0;
    else if (r < 85) return $urandom_range(3, 1);
    else if (r < 97) return $urandom_range(12, 4);
    else return $urandom_range(60, 20);
  endfunction

  // one lookup against the bench state: hit search, else first invalid
  // way, else smallest stamp with the lowest way winning ties
  function automatic lookup_result_t predict_lookup(input logic [31:0] addr);
    lookup_result_t res;
    logic [31:0]    shifted;
    logic [31:0]    imask;
    logic [31:0]    tag;
    logic [31:0]    best;
    int             sh;
    int             set_no;
    int             nways;
    int             base;
    int             victim;
    int             w;
    bit             found;
    bit             have_best;
    bit             done;
    sh      = cur_offset_bits + cur_index_bits;
    shifted = addr >> cur_offset_bits;
    imask   = (32'd1 << cur_index_bits) - 32'd1;
    // index bits above the store alias back onto it
    set_no  = (shifted & imask) % SACL_SETS;
    tag     = addr >> sh;
    // zero ways acts as one, more than the store has saturates
    if (cur_ways == 4'd0) nways = 1;
    else if (cur_ways > SACL_WAYS) nways = SACL_WAYS;
    else nways = cur_ways;
    base      = set_no * SACL_WAYS;
    found     = 1'b0;
    have_best = 1'b0;
    done      = 1'b0;
    victim    = 0;
    best      = '0;
    for (w = 0; w < nways && !found; w++) begin
      if (line_valid[base + w] && line_tag[base + w] == tag) begin
        found  = 1'b1;
        victim = w;
      end
    end
    if (found) begin
      hit_tally++;
      line_stamp[base + victim] = stamp_clock;
    end else begin
      for (w = 0; w < nways && !done; w++) begin
        if (!line_valid[base + w]) begin
          victim = w;
          done   = 1'b1;
        end else if (!have_best || line_stamp[base + w] < best) begin
          have_best = 1'b1;
          best      = line_stamp[base + w];
          victim    = w;
        end
      end
      miss_tally++;
      line_valid[base + victim] = 1'b1;
      line_tag[base + victim]   = tag;
      line_stamp[base + victim] = stamp_clock;
    end
    stamp_clock++;
    res.hit    = found;
    res.way    = victim[2:0];
    res.hits   = hit_tally;
    res.misses = miss_tally;
    return res;
  endfunction

  // builds an address from tag, set field and in-block bits under the
  // geometry currently programmed
  function automatic logic [31:0] make_address(input logic [31:0] tag,
                                               input logic [14:0] set_field,
                                               input logic [31:0] low);
    logic [31:0] imask;
    logic [31:0] omask;
    int          sh;
    sh    = cur_offset_bits + cur_index_bits;
    imask = (32'd1 << cur_index_bits) - 32'd1;
    omask = (32'd1 << cur_offset_bits) - 32'd1;
    return (tag << sh) | (({17'd0, set_field} & imask) << cur_offset_bits) | (low & omask);
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: mismatch on %s, got %0h want %0h", $time, field, got, want);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // driver: predicts at acceptance, then loads the next address or a gap
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall)
        results_due.push_back(predict_lookup(address));
      // the slot is free once the current item went through or none is up
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (addr_backlog.size() > 0) begin
          in_valid <= 1'b1;
          address  <= addr_backlog.pop_front();
          gap_left <= sender_quiet ? 0 : pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks each result item, then picks next cycle's stall
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
      hold_left  <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          report_mismatch("item with nothing due (misses)", misses, '0);
        end else begin
          due = results_due.pop_front();
          if (hit !== due.hit)       report_mismatch("hit", hit, due.hit);
          if (way !== due.way)       report_mismatch("way", way, due.way);
          if (hits !== due.hits)     report_mismatch("hits", hits, due.hits);
          if (misses !== due.misses) report_mismatch("misses", misses, due.misses);
        end
      end
      // a fresh hold request starts the long hold-off, counted here
      if (hold_seen != hold_req) begin
        hold_seen <= hold_req;
        hold_left <= LONG_HOLD - 1;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall  <= 1'b1;
      end else if (!receiver_quiet && $urandom_range(99) < 25) begin
        stall_left <= pick_gap();
        out_stall  <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: gives up after a long run of cycles with no handshake
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("tb_set_assoc_cache_lru_lookup: errors");
    $finish;
  end

  // one register write; the bench copy follows at the handshake edge
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_OFFSET_BITS: cur_offset_bits = val[2:0];
      REG_INDEX_BITS:  cur_index_bits  = val;
      REG_WAYS_IN_USE: cur_ways        = val;
      default: ;  // undecoded index, no effect
    endcase
    cfg_valid <= 1'b0;
  endtask

  // sender holds off until every item is offered and every result is back,
  // then a short settle so the block is idle; checked mid-cycle so the
  // driver and monitor updates of the last edge are all visible
  task automatic drain_and_settle();
    while (!(addr_backlog.size() == 0 && !in_valid && results_due.size() == 0))
      @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // random items over a small pool of tags and sets, so that lines hit,
  // fill and get evicted; some exact repeats and some noise
  task automatic fill_phase(input int count);
    logic [31:0] tag_pool [10];
    logic [14:0] set_pool [3];
    logic [14:0] sf;
    logic [31:0] a;
    logic [31:0] recent;
    int          n_tags;
    int          k;
    int          r;
    for (k = 0; k < 10; k++) tag_pool[k] = $urandom;
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    for (k = 0; k < 3; k++) set_pool[k] = 15'($urandom);
    n_tags = $urandom_range(10, 2);
    recent = $urandom;
    for (k = 0; k < count; k++) begin
      r = $urandom_range(99);
      if (r < 75) begin
        sf = set_pool[$urandom_range(2)];
        // flip index bits above the store so aliased sets meet
        if ($urandom_range(4) == 0) sf = sf ^ (15'($urandom) << 10);
        a = make_address(tag_pool[$urandom_range(n_tags - 1)], sf, $urandom);
      end else if (r < 88) begin
        a = recent;
      end else begin
        a = $urandom;
      end
      recent = a;
      addr_backlog.push_back(a);
    end
  endtask

  task automatic run_phase(input logic [3:0] off_val, input logic [3:0] idx_val,
                           input logic [3:0] ways_val, input bit quiet_tx,
                           input bit quiet_rx, input bit long_hold);
    write_reg(REG_OFFSET_BITS, off_val);
    write_reg(REG_INDEX_BITS, idx_val);
    write_reg(REG_WAYS_IN_USE, ways_val);
    sender_quiet   = quiet_tx;
    receiver_quiet = quiet_rx;
    if (long_hold) hold_req++;
    fill_phase(PHASE_ITEMS);
    drain_and_settle();
  endtask

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  initial begin : sequencer
    int k;
    for (k = 0; k < LINES; k++) begin
      line_valid[k] = 1'b0;
      line_tag[k]   = '0;
      line_stamp[k] = '0;
    end
    stamp_clock     = '0;
    hit_tally       = '0;
    miss_tally      = '0;
    cur_offset_bits = OFFSET_BITS_RST;
    cur_index_bits  = INDEX_BITS_RST;
    cur_ways        = WAYS_IN_USE_RST;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed warm-up on the reset geometry
    foreach (WARMUP_ADDRS[i]) addr_backlog.push_back(WARMUP_ADDRS[i]);
    drain_and_settle();

    // one set, one way
    run_phase(4'd0, 4'd0, 4'd1, 1'b0, 1'b0, 1'b0);
    // widest split, index beyond the store, all ways
    run_phase(4'd7, 4'd15, 4'd8, 1'b0, 1'b0, 1'b0);
    // offset write with the top data bit set, ways above the store
    run_phase(4'd11, 4'd12, 4'd15, 1'b0, 1'b0, 1'b0);
    // zero ways
    run_phase(4'd3, 4'd4, 4'd0, 1'b0, 1'b0, 1'b0);
    // receiver holds off while the sender keeps offering back to back
    run_phase(4'd15, 4'd10, 4'd9, 1'b1, 1'b0, 1'b1);
    // no idling on either side
    run_phase(4'd1, 4'd10, 4'd8, 1'b1, 1'b1, 1'b0);
    // write to an undecoded register must leave the geometry alone
    write_reg(REG_UNUSED, 4'd1);
    run_phase(4'd2, 4'd6, 4'd5, 1'b0, 1'b0, 1'b0);
    // back to the reset geometry, old lines come back into view
    run_phase(4'd2, 4'd10, 4'd4, 1'b0, 1'b0, 1'b0);

    for (k = 0; k < 8; k++)
      run_phase(4'($urandom), 4'($urandom), 4'($urandom),
                $urandom_range(3) == 0, $urandom_range(3) == 0, 1'b0);

    if (mismatch_count == 0 && results_due.size() == 0)
      $display("tb_set_assoc_cache_lru_lookup: clean");
    else
      $display("tb_set_assoc_cache_lru_lookup: errors");
    $finish;
  end

endmodule

// ===== set_assoc_cache_lru_lookup.f =====
+incdir+sv
sv/sacl_pkg.sv
sv/sacl_set_map.sv
sv/sacl_tag_ram.sv
sv/sacl_lru_pick.sv
sv/set_assoc_cache_lru_lookup.sv
test/tb_set_assoc_cache_lru_lookup.sv
